@@ hw/rtl/mevd_pkg.sv @@
// Shared types and codes for the MIDI event voice dispatcher.
package mevd_pkg;

   // Event classes decoded from the status byte
   localparam logic [3:0] KIND_OFF   = 4'd0;
   localparam logic [3:0] KIND_ON    = 4'd1;
   localparam logic [3:0] KIND_KEYP  = 4'd2;
   localparam logic [3:0] KIND_VOL   = 4'd3;
   localparam logic [3:0] KIND_NOP   = 4'd4;
   localparam logic [3:0] KIND_PROG  = 4'd5;
   localparam logic [3:0] KIND_CHANP = 4'd6;
   localparam logic [3:0] KIND_BEND  = 4'd7;
   localparam logic [3:0] KIND_SYS   = 4'd8;
   localparam logic [3:0] KIND_BAD   = 4'd9;

   // Voice commands
   localparam logic [2:0] CMD_PATCH = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_VOL   = 3'd3;
   localparam logic [2:0] CMD_BEND  = 3'd4;
   localparam logic [2:0] CMD_KEYP  = 3'd5;
   localparam logic [2:0] CMD_CHANP = 3'd6;
   localparam logic [2:0] CMD_NONE  = 3'd7;

   // Event status codes
   localparam logic [1:0] EVST_OK      = 2'd0;
   localparam logic [1:0] EVST_END     = 2'd1;
   localparam logic [1:0] EVST_UNKNOWN = 2'd2;

   localparam logic [7:0] FREE_NOTE     = 8'hFF;
   localparam logic [4:0] FREE_CHANNEL  = 5'h1F;
   localparam logic [6:0] CTRL_MAIN_VOL = 7'd7;
   localparam logic [15:0] DRUM_MASK_RESET = 16'h0200;

   localparam int MAX_VOICES = 32;

   typedef struct packed {
      logic [2:0]  command;
      logic [4:0]  voice_index;
      logic [13:0] value_main;
      logic [6:0]  value_extra;
      logic [1:0]  event_status;
      logic        last_result;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // latch a new request
      logic step;        // advance scan index
      logic push;        // move held result to output, not last
      logic hold_new;    // capture result for current voice
      logic hold_start;  // capture start command after a patch
      logic finish;      // emit final result of the request
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic match;
      logic at_end;
      logic out_free;
      logic hold_valid;
      logic scans;
      logic first_only;
      logic note_on;
   } stat_type;

endpackage

@@ hw/rtl/mevd_if.sv @@
// Handshake channel interfaces for requests, results and the control register.
interface mevd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] status_byte;
   logic [6:0] data_first;
   logic [6:0] data_second;
   modport source(output valid, status_byte, data_first, data_second, input ready);
   modport sink(input valid, status_byte, data_first, data_second, output ready);
endinterface

interface mevd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [4:0]  voice_index;
   logic [13:0] value_main;
   logic [6:0]  value_extra;
   logic [1:0]  event_status;
   logic        last_result;
   modport source(output valid, command, voice_index, value_main, value_extra,
                  event_status, last_result, input ready);
   modport sink(input valid, command, voice_index, value_main, value_extra,
                event_status, last_result, output ready);
endinterface

interface mevd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

@@ hw/rtl/mevd_datapath.sv @@
// Datapath: request registers, voice and program tables, held and output results.
module mevd_datapath #(
   parameter int NUM_VOICES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         status_byte,
   input  logic [6:0]         data_first,
   input  logic [6:0]         data_second,
   input  logic               mask_we,
   input  logic [15:0]        mask_data,
   input  mevd_pkg::cmd_type  cmd,
   output mevd_pkg::stat_type stat,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output mevd_pkg::rsp_type  rsp
);
   import mevd_pkg::*;

   localparam int VCOUNT = (NUM_VOICES > MAX_VOICES) ? MAX_VOICES :
                           ((NUM_VOICES < 1) ? 1 : NUM_VOICES);
   localparam int IDX_W  = (VCOUNT > 1) ? $clog2(VCOUNT) : 1;

   logic [15:0]      mask_ff;
   logic [3:0]       kind_ff, kind_in;
   logic [1:0]       evst_ff, evst_in;
   logic [3:0]       chan_ff;
   logic [6:0]       d1_ff, d2_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       note_ff [VCOUNT];
   logic [4:0]       vch_ff  [VCOUNT];
   logic [6:0]       prog_ff [16];
   rsp_type          hold_ff, hold_in;
   logic             hold_valid_ff, hold_valid_in;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic [7:0]  cur_note;
   logic [4:0]  cur_ch;
   logic        hit_note, hit_chan, hit_free, match;
   logic [13:0] patch;
   rsp_type     new_res, start_res, none_res;

   // Decode the incoming status byte
   always_comb begin
      kind_in = KIND_BAD;
      evst_in = EVST_OK;
      if (!status_byte[7]) begin
         kind_in = KIND_BAD;
         evst_in = EVST_UNKNOWN;
      end else begin
         unique case (status_byte[6:4])
            3'd0: kind_in = KIND_OFF;
            3'd1: kind_in = (data_second == 7'd0) ? KIND_OFF : KIND_ON;
            3'd2: kind_in = KIND_KEYP;
            3'd3: kind_in = (data_first == CTRL_MAIN_VOL) ? KIND_VOL : KIND_NOP;
            3'd4: kind_in = KIND_PROG;
            3'd5: kind_in = KIND_CHANP;
            3'd6: kind_in = KIND_BEND;
            default: begin
               kind_in = KIND_SYS;
               evst_in = EVST_END;
            end
         endcase
      end
   end

   assign cur_note = note_ff[idx_ff];
   assign cur_ch   = vch_ff[idx_ff];
   assign hit_chan = (cur_ch == {1'b0, chan_ff});
   assign hit_note = hit_chan && (cur_note == {1'b0, d1_ff});
   assign hit_free = (cur_note == FREE_NOTE) && (cur_ch == FREE_CHANNEL);

   always_comb begin
      case (kind_ff) inside
         KIND_OFF, KIND_KEYP:             match = hit_note;
         KIND_ON:                         match = hit_free;
         KIND_VOL, KIND_CHANP, KIND_BEND: match = hit_chan;
         default:                         match = 1'b0;
      endcase
   end

   assign patch = mask_ff[chan_ff] ? (14'(d1_ff) + 14'd128) : 14'(prog_ff[chan_ff]);

   always_comb begin
      new_res              = '0;
      new_res.voice_index  = 5'(idx_ff);
      new_res.event_status = evst_ff;
      case (kind_ff)
         KIND_OFF: begin
            new_res.command     = CMD_STOP;
            new_res.value_main  = 14'(d1_ff);
            new_res.value_extra = d2_ff;
         end
         KIND_ON: begin
            new_res.command    = CMD_PATCH;
            new_res.value_main = patch;
         end
         KIND_KEYP: begin
            new_res.command     = CMD_KEYP;
            new_res.value_main  = 14'(d1_ff);
            new_res.value_extra = d2_ff;
         end
         KIND_VOL: begin
            new_res.command    = CMD_VOL;
            new_res.value_main = 14'(d2_ff);
         end
         KIND_CHANP: begin
            new_res.command    = CMD_CHANP;
            new_res.value_main = 14'(d1_ff);
         end
         KIND_BEND: begin
            new_res.command    = CMD_BEND;
            new_res.value_main = {d2_ff, d1_ff};
         end
         default: new_res.command = CMD_NONE;
      endcase
   end

   always_comb begin
      start_res             = hold_ff;
      start_res.command     = CMD_START;
      start_res.value_main  = 14'(d1_ff);
      start_res.value_extra = d2_ff;
      none_res              = '0;
      none_res.command      = CMD_NONE;
      none_res.event_status = evst_ff;
      none_res.last_result  = 1'b1;
   end

   always_comb begin
      idx_in        = idx_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      if (cmd.load) begin
         idx_in        = '0;
         hold_valid_in = 1'b0;
      end else if (cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.hold_new) begin
         hold_in       = new_res;
         hold_valid_in = 1'b1;
      end else if (cmd.hold_start) begin
         hold_in       = start_res;
         hold_valid_in = 1'b1;
      end else if (cmd.finish) begin
         hold_valid_in = 1'b0;
      end
      if (cmd.push) begin
         out_in             = hold_ff;
         out_in.last_result = 1'b0;
         out_valid_in       = 1'b1;
      end else if (cmd.finish) begin
         if (hold_valid_ff) begin
            out_in             = hold_ff;
            out_in.last_result = 1'b1;
         end else begin
            out_in = none_res;
         end
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= DRUM_MASK_RESET;
         kind_ff       <= KIND_NOP;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         for (int i = 0; i < VCOUNT; i++) begin
            note_ff[i] <= FREE_NOTE;
            vch_ff[i]  <= FREE_CHANNEL;
         end
         for (int c = 0; c < 16; c++) begin
            prog_ff[c] <= '0;
         end
      end else begin
         if (mask_we) begin
            mask_ff <= mask_data;
         end
         if (cmd.load) begin
            kind_ff <= kind_in;
            evst_ff <= evst_in;
            chan_ff <= status_byte[3:0];
            d1_ff   <= data_first;
            d2_ff   <= data_second;
            if (kind_in == KIND_PROG) begin
               prog_ff[status_byte[3:0]] <= data_first;
            end
         end
         // claim or release the voice found by a note search
         if (cmd.hold_new && kind_ff == KIND_ON) begin
            note_ff[idx_ff] <= {1'b0, d1_ff};
            vch_ff[idx_ff]  <= {1'b0, chan_ff};
         end else if (cmd.hold_new && kind_ff == KIND_OFF) begin
            note_ff[idx_ff] <= FREE_NOTE;
            vch_ff[idx_ff]  <= FREE_CHANNEL;
         end
         idx_ff        <= idx_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   always_comb begin
      stat.match      = match;
      stat.at_end     = (idx_ff == IDX_W'(VCOUNT - 1));
      stat.out_free   = !out_valid_ff || rsp_ready;
      stat.hold_valid = hold_valid_ff;
      stat.scans      = (kind_ff == KIND_OFF) || (kind_ff == KIND_ON) ||
                        (kind_ff == KIND_KEYP) || (kind_ff == KIND_VOL) ||
                        (kind_ff == KIND_CHANP) || (kind_ff == KIND_BEND);
      stat.first_only = (kind_ff == KIND_OFF) || (kind_ff == KIND_ON);
      stat.note_on    = (kind_ff == KIND_ON);
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

@@ hw/rtl/mevd_ctrl.sv @@
// Controller: sequences the voice scan and the release of results.
module mevd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mevd_pkg::stat_type stat,
   output mevd_pkg::cmd_type  cmd
);
   import mevd_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_ON2   = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       go;

   // a match needs room to release the previously held result
   assign go = !stat.match || !stat.hold_valid || stat.out_free;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!stat.scans) begin
               state_in = S_FLUSH;
            end else if (go) begin
               cmd.step = 1'b1;
               if (stat.match) begin
                  cmd.push     = stat.hold_valid;
                  cmd.hold_new = 1'b1;
               end
               if (stat.match && stat.first_only) begin
                  state_in = stat.note_on ? S_ON2 : S_FLUSH;
               end else if (stat.at_end) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_ON2: begin
            // release the patch, then hold the start
            if (stat.out_free) begin
               cmd.push       = 1'b1;
               cmd.hold_start = 1'b1;
               state_in       = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/midi_event_voice_dispatch_core.sv @@
// MIDI event voice dispatcher: top level.
// Takes one MIDI channel event per request on req_ch (status byte and two data
// bytes) and returns one or more voice commands on rsp_ch; last_result marks
// the final command of each request. Events that cause no command return one
// "none" result carrying the event status.
// The drum channel mask is written through csr_ch, which is always ready; write
// it only while no request is in flight.
// Timing: a request is taken in the idle state, then the voice table is scanned one
// voice per cycle by a single compare unit while the output can take results,
// followed by a flush state that releases the final result. A note-on passes
// through a further state that releases its patch before the flush. Note-on and
// note-off searches stop at the first hit; program change, other controllers,
// system and unknown events skip the scan. req_ch.ready is high only between
// requests.
// Results leave through an output register; a stalled receiver holds the scan
// at the next result, and a new request can be taken while the last result of
// the previous one still waits.
// Reset frees all voices, clears all channel programs to zero and sets the
// drum mask to channel 9.
module midi_event_voice_dispatch_core #(
   parameter int NUM_VOICES = 32
) (
   input  logic       clock,
   input  logic       reset,
   mevd_req_if.sink   req_ch,
   mevd_rsp_if.source rsp_ch,
   mevd_csr_if.sink   csr_ch
);
   import mevd_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   rsp_type  rsp;
   logic     rsp_valid;

   assign csr_ch.ready = 1'b1;

   mevd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mevd_datapath #(
      .NUM_VOICES (NUM_VOICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .status_byte (req_ch.status_byte),
      .data_first  (req_ch.data_first),
      .data_second (req_ch.data_second),
      .mask_we     (csr_ch.valid),
      .mask_data   (csr_ch.data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.command      = rsp.command;
   assign rsp_ch.voice_index  = rsp.voice_index;
   assign rsp_ch.value_main   = rsp.value_main;
   assign rsp_ch.value_extra  = rsp.value_extra;
   assign rsp_ch.event_status = rsp.event_status;
   assign rsp_ch.last_result  = rsp.last_result;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the MIDI event voice dispatcher: random and directed events.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mevd_pkg::*;

   localparam int NUM_VOICES  = 32;
   localparam int VOICE_COUNT = (NUM_VOICES > 32) ? 32 :
                                ((NUM_VOICES < 1) ? 1 : NUM_VOICES);
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PER_PHASE = 68;

   // Event kinds from the high nibble of the status byte
   localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
   localparam logic [3:0] ST_NOTE_ON    = 4'h9;
   localparam logic [3:0] ST_KEY_PRESS  = 4'hA;
   localparam logic [3:0] ST_CONTROL    = 4'hB;
   localparam logic [3:0] ST_PROGRAM    = 4'hC;
   localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
   localparam logic [3:0] ST_BEND       = 4'hE;
   localparam logic [3:0] ST_SYSTEM     = 4'hF;

   typedef struct packed {
      logic [7:0] status;
      logic [6:0] d1;
      logic [6:0] d2;
   } midi_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mevd_req_if req_ch();
   mevd_rsp_if rsp_ch();
   mevd_csr_if csr_ch();

   midi_event_voice_dispatch_core #(.NUM_VOICES(NUM_VOICES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   // Predictor state
   logic [15:0] drum_mask;
   logic [7:0]  voice_note [VOICE_COUNT];
   logic [4:0]  voice_chan [VOICE_COUNT];
   logic [6:0]  chan_program [16];

   midi_event_type midi_backlog[$];
   rsp_type        due_cmds[$];
   logic [10:0]    sounding[$];     // {channel, note} as the generator sees it

   int  mismatch_count = 0;
   int  cmds_checked = 0;
   int  events_sent = 0;
   int  mask_writes = 0;
   int  cycle_count = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  long_hold = 0;
   bit  idle_on = 1'b1;
   bit  rsp_hold_req = 1'b0;
   bit  req_fire = 1'b0;

   function automatic int pick_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic rsp_type make_cmd(logic [2:0] cmd, int voice,
                                        logic [13:0] main_val, logic [6:0] extra);
      rsp_type r;
      r.command      = cmd;
      r.voice_index  = voice[4:0];
      r.value_main   = main_val;
      r.value_extra  = extra;
      r.event_status = EVST_OK;
      r.last_result  = 1'b0;
      return r;
   endfunction

   function automatic void clear_voices();
      for (int v = 0; v < VOICE_COUNT; v++) begin
         voice_note[v] = FREE_NOTE;
         voice_chan[v] = FREE_CHANNEL;
      end
      for (int c = 0; c < 16; c++) chan_program[c] = '0;
      drum_mask = DRUM_MASK_RESET;
   endfunction

   // Work out the voice commands that one accepted event produces
   function automatic void dispatch_event(midi_event_type ev);
      logic [3:0]  kind;
      logic [3:0]  chan;
      logic [1:0]  evst;
      logic [13:0] patch;
      int          hit;
      rsp_type     batch[$];
      kind = ev.status[7:4];
      chan = ev.status[3:0];
      evst = EVST_OK;
      hit  = -1;
      if (kind == ST_NOTE_ON && ev.d2 == 7'd0) kind = ST_NOTE_OFF;
      case (kind)
         ST_NOTE_OFF: begin
            for (int v = 0; v < VOICE_COUNT; v++)
               if (hit < 0 && voice_note[v] == {1'b0, ev.d1} &&
                   voice_chan[v] == {1'b0, chan})
                  hit = v;
            if (hit >= 0) begin
               voice_note[hit] = FREE_NOTE;
               voice_chan[hit] = FREE_CHANNEL;
               batch.push_back(make_cmd(CMD_STOP, hit, 14'(ev.d1), ev.d2));
            end
         end
         ST_NOTE_ON: begin
            for (int v = 0; v < VOICE_COUNT; v++)
               if (hit < 0 && voice_note[v] == FREE_NOTE && voice_chan[v] == FREE_CHANNEL)
                  hit = v;
            if (hit >= 0) begin
               voice_note[hit] = {1'b0, ev.d1};
               voice_chan[hit] = {1'b0, chan};
               patch = drum_mask[chan] ? 14'(ev.d1) + 14'd128 : 14'(chan_program[chan]);
               batch.push_back(make_cmd(CMD_PATCH, hit, patch, 7'd0));
               batch.push_back(make_cmd(CMD_START, hit, 14'(ev.d1), ev.d2));
            end
         end
         ST_KEY_PRESS: begin
            for (int v = 0; v < VOICE_COUNT; v++)
               if (voice_note[v] == {1'b0, ev.d1} && voice_chan[v] == {1'b0, chan})
                  batch.push_back(make_cmd(CMD_KEYP, v, 14'(ev.d1), ev.d2));
         end
         ST_CONTROL: begin
            if (ev.d1 == CTRL_MAIN_VOL)
               for (int v = 0; v < VOICE_COUNT; v++)
                  if (voice_chan[v] == {1'b0, chan})
                     batch.push_back(make_cmd(CMD_VOL, v, 14'(ev.d2), 7'd0));
         end
         ST_PROGRAM: chan_program[chan] = ev.d1;
         ST_CHAN_PRESS: begin
            for (int v = 0; v < VOICE_COUNT; v++)
               if (voice_chan[v] == {1'b0, chan})
                  batch.push_back(make_cmd(CMD_CHANP, v, 14'(ev.d1), 7'd0));
         end
         ST_BEND: begin
            for (int v = 0; v < VOICE_COUNT; v++)
               if (voice_chan[v] == {1'b0, chan})
                  batch.push_back(make_cmd(CMD_BEND, v, {ev.d2, ev.d1}, 7'd0));
         end
         ST_SYSTEM: evst = EVST_END;
         default:   evst = EVST_UNKNOWN;
      endcase
      if (batch.size() == 0) batch.push_back(make_cmd(CMD_NONE, 0, 14'd0, 7'd0));
      foreach (batch[i]) begin
         batch[i].event_status = evst;
         batch[i].last_result  = (i == batch.size() - 1);
         due_cmds.push_back(batch[i]);
      end
   endfunction

   function automatic void queue_event(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
      midi_event_type ev;
      ev.status = status;
      ev.d1     = d1;
      ev.d2     = d2;
      midi_backlog.push_back(ev);
   endfunction

   function automatic logic [3:0] pick_channel();
      if ($urandom_range(0, 1)) return 4'($urandom_range(0, 3));
      return 4'($urandom_range(0, 15));
   endfunction

   // Mostly musical traffic on a few channels, some noise and bad status bytes
   function automatic void queue_random_event();
      int unsigned r;
      int          idx;
      logic [3:0]  chan;
      logic [6:0]  note;
      r    = $urandom_range(0, 99);
      chan = pick_channel();
      note = 7'($urandom_range(0, 127));
      if ((r >= 25 && r < 58) && sounding.size() > 0) begin
         idx  = $urandom_range(0, sounding.size() - 1);
         chan = sounding[idx][10:7];
         note = sounding[idx][6:0];
      end
      if (r < 25) begin
         queue_event({ST_NOTE_ON, chan}, note, 7'($urandom_range(1, 127)));
         sounding.push_back({chan, note});
      end else if (r < 50) begin
         if (sounding.size() > 0) sounding.delete(idx);
         if ($urandom_range(0, 1)) queue_event({ST_NOTE_ON, chan}, note, 7'd0);
         else queue_event({ST_NOTE_OFF, chan}, note, 7'($urandom_range(0, 127)));
      end else if (r < 58) begin
         queue_event({ST_KEY_PRESS, chan}, note, 7'($urandom_range(0, 127)));
      end else if (r < 66) begin
         queue_event({ST_CONTROL, chan},
                     ($urandom_range(0, 3) != 0) ? CTRL_MAIN_VOL : note,
                     7'($urandom_range(0, 127)));
      end else if (r < 72) begin
         queue_event({ST_PROGRAM, chan}, note, 7'($urandom_range(0, 127)));
      end else if (r < 80) begin
         queue_event({ST_CHAN_PRESS, chan}, note, 7'($urandom_range(0, 127)));
      end else if (r < 88) begin
         queue_event({ST_BEND, chan}, note, 7'($urandom_range(0, 127)));
      end else if (r < 93) begin
         queue_event({ST_SYSTEM, 4'($urandom_range(0, 15))}, note,
                     7'($urandom_range(0, 127)));
      end else if (r < 96) begin
         queue_event(8'($urandom_range(0, 127)), note, 7'($urandom_range(0, 127)));
      end else begin
         queue_event(8'($urandom_range(0, 255)), note, 7'($urandom_range(0, 127)));
      end
   endfunction

   function automatic string show_cmd(rsp_type r);
      return $sformatf("cmd %0d voice %0d main %0d extra %0d st %0d last %0d",
                       r.command, r.voice_index, r.value_main, r.value_extra,
                       r.event_status, r.last_result);
   endfunction

   task automatic flag_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected %s, got %s", $realtime, what, show_cmd(want),
                  show_cmd(got));
   endtask

   // Request driver: hold until taken, then advance after a random gap
   always @(negedge clock) begin
      midi_event_type ev;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         // hold the offered request
      end else if (req_gap > 0) begin
         req_gap--;
         req_ch.valid <= 1'b0;
      end else if (midi_backlog.size() > 0) begin
         ev = midi_backlog.pop_front();
         req_ch.status_byte <= ev.status;
         req_ch.data_first  <= ev.d1;
         req_ch.data_second <= ev.d2;
         req_ch.valid       <= 1'b1;
         req_gap = pick_gap();
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Result receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_req) begin
         long_hold = LONG_HOLD_CYCLES;
         rsp_hold_req = 1'b0;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   // Predict on each accepted request
   always @(posedge clock) begin
      midi_event_type ev;
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         ev.status = req_ch.status_byte;
         ev.d1     = req_ch.data_first;
         ev.d2     = req_ch.data_second;
         dispatch_event(ev);
         events_sent++;
      end
   end

   // Check each accepted result against the oldest prediction
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.command      = rsp_ch.command;
         got.voice_index  = rsp_ch.voice_index;
         got.value_main   = rsp_ch.value_main;
         got.value_extra  = rsp_ch.value_extra;
         got.event_status = rsp_ch.event_status;
         got.last_result  = rsp_ch.last_result;
         if (due_cmds.size() == 0) begin
            flag_mismatch("unexpected result", got, got);
         end else begin
            want = due_cmds.pop_front();
            cmds_checked++;
            if (got.command !== want.command || got.voice_index !== want.voice_index ||
                got.value_main !== want.value_main || got.value_extra !== want.value_extra ||
                got.event_status !== want.event_status ||
                got.last_result !== want.last_result)
               flag_mismatch("result mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  due_cmds.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic wait_idle();
      @(posedge clock);
      while (midi_backlog.size() != 0 || req_ch.valid || due_cmds.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_drum_mask(logic [15:0] value);
      @(negedge clock);
      csr_ch.data  <= value;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      drum_mask = value;
      mask_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_random_phase(logic [15:0] mask, bit with_idle);
      wait_idle();
      write_drum_mask(mask);
      idle_on = with_idle;
      repeat (RANDOM_PER_PHASE) queue_random_event();
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.status_byte = '0;
      req_ch.data_first  = '0;
      req_ch.data_second = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = '0;
      clear_voices();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every event kind, drum channel, empty matches
      queue_event(8'h90, 7'd0, 7'd127);
      queue_event(8'hC0, 7'd127, 7'd0);
      queue_event(8'h90, 7'd127, 7'd1);
      queue_event(8'h99, 7'd127, 7'd127);
      queue_event(8'h99, 7'd0, 7'd5);
      queue_event(8'hA0, 7'd0, 7'd127);
      queue_event(8'hA0, 7'd5, 7'd9);
      queue_event(8'hB0, CTRL_MAIN_VOL, 7'd127);
      queue_event(8'hB0, 7'd8, 7'd100);
      queue_event(8'hD0, 7'd127, 7'd0);
      queue_event(8'hE0, 7'd127, 7'd127);
      queue_event(8'hE0, 7'd0, 7'd0);
      queue_event(8'hD5, 7'd10, 7'd0);
      queue_event(8'h90, 7'd127, 7'd0);
      queue_event(8'h80, 7'd127, 7'd64);
      queue_event(8'h80, 7'd0, 7'd0);
      queue_event(8'h89, 7'd127, 7'd127);
      queue_event(8'hF0, 7'd0, 7'd0);
      queue_event(8'hFF, 7'd127, 7'd127);
      queue_event(8'h00, 7'd0, 7'd0);
      queue_event(8'h7F, 7'd127, 7'd127);
      queue_event(8'h9F, 7'd55, 7'd127);
      queue_event(8'hBF, CTRL_MAIN_VOL, 7'd0);
      queue_event(8'h8F, 7'd55, 7'd0);
      queue_event(8'h89, 7'd0, 7'd1);

      // Fill the whole voice table on one channel under a long receiver stall
      wait_idle();
      write_drum_mask(16'h0008);
      idle_on = 1'b0;
      rsp_hold_req = 1'b1;
      for (int n = 0; n < VOICE_COUNT + 2; n++) queue_event(8'h93, 7'(n), 7'(n + 1));
      repeat (3) queue_event(8'hE3, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      queue_event(8'hB3, CTRL_MAIN_VOL, 7'($urandom_range(0, 127)));
      queue_event(8'hD3, 7'($urandom_range(0, 127)), 7'd0);
      queue_event(8'hA3, 7'd5, 7'($urandom_range(0, 127)));
      for (int n = 0; n < VOICE_COUNT + 2; n++)
         queue_event(8'h83, 7'(n), 7'($urandom_range(0, 127)));

      run_random_phase(16'hFFFF, 1'b1);
      run_random_phase(16'h0000, 1'b0);
      run_random_phase(16'($urandom_range(0, 65535)), 1'b1);
      run_random_phase(DRUM_MASK_RESET, 1'b1);

      wait_idle();
      $display("%0d events dispatched, %0d voice commands checked, %0d mismatches",
               events_sent, cmds_checked, mismatch_count);
      $display("%0d drum mask settings, one long result stall with a full voice table",
               mask_writes);
      if (mismatch_count == 0 && due_cmds.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/mevd_pkg.sv
hw/rtl/mevd_if.sv
hw/rtl/mevd_datapath.sv
hw/rtl/mevd_ctrl.sv
hw/rtl/midi_event_voice_dispatch_core.sv
test/testbench.sv
